// ----- design/efd_pkg.sv -----
// Shared constants, register codes and inter-module types of the frame decoder.
package efd_pkg;

  localparam int BYTE_W      = 8;
  localparam int MSG_LEN_W   = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int GUARD_BYTES = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ESC   = 2'd2;

  localparam logic [BYTE_W-1:0] START_RST = 8'd2;
  localparam logic [BYTE_W-1:0] END_RST   = 8'd3;
  localparam logic [BYTE_W-1:0] ESC_RST   = 8'd16;

  // Release job handed from front to back.
  typedef struct packed {
    logic                 bank;
    logic                 empty;
    logic [MSG_LEN_W-1:0] len;
  } job_t;

  // Back end frees a buffer bank once its last byte has been read.
  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

endpackage

// ----- design/efd_in_if.sv -----
// Receive byte channel.
interface efd_in_if;
  logic                       valid;
  logic                       ready;
  logic [efd_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- design/efd_out_if.sv -----
// Decoded message byte channel.
interface efd_out_if;
  logic                          valid;
  logic                          ready;
  logic [efd_pkg::BYTE_W-1:0]    msg_byte;
  logic [efd_pkg::MSG_LEN_W-1:0] msg_length;
  logic                          is_last;
  logic                          empty_frame;

  modport source (output valid, output msg_byte, output msg_length, output is_last,
                  output empty_frame, input ready);
  modport sink   (input valid, input msg_byte, input msg_length, input is_last,
                  input empty_frame, output ready);
endinterface

// ----- design/efd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module efd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/efd_front.sv -----
// Front end: pattern registers, byte classification, payload writes and job issue.
module efd_front #(
  parameter int MAX_BYTES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  efd_in_if.sink                        in_ch,
  input  logic                          cfg_wr_en,
  input  logic [efd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [efd_pkg::BYTE_W-1:0]    cfg_wdata,
  output logic                          push_valid,
  output efd_pkg::job_t                 push_job,
  input  logic                          fifo_full,
  input  efd_pkg::release_t             rel,
  output logic                          ram_we,
  output logic [$clog2(MAX_BYTES):0]    ram_waddr,
  output logic [efd_pkg::BYTE_W-1:0]    ram_wdata
);

  localparam int AW = $clog2(MAX_BYTES);
  localparam int LW = efd_pkg::MSG_LEN_W;
  localparam logic [AW-1:0] LIMIT = AW'(MAX_BYTES - efd_pkg::GUARD_BYTES);
  localparam logic [AW-1:0] LAST  = AW'(MAX_BYTES - 1);

  logic [efd_pkg::BYTE_W-1:0] start_r, end_r, esc_r;
  logic          in_frame_r, in_frame_nxt;
  logic          esc_pend_r, esc_pend_nxt;
  logic [AW-1:0] fill_r, fill_nxt;
  logic          bank_r, bank_nxt;
  logic [1:0]    busy_r, busy_nxt;
  logic          accept;
  logic [efd_pkg::BYTE_W-1:0] b;

  assign b           = in_ch.rx_byte;
  assign in_ch.ready = !busy_r[bank_r] && !fifo_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign ram_waddr   = {bank_r, fill_r};
  assign ram_wdata   = b;

  always_comb begin
    in_frame_nxt   = in_frame_r;
    esc_pend_nxt   = esc_pend_r;
    fill_nxt       = fill_r;
    bank_nxt       = bank_r;
    busy_nxt       = busy_r;
    ram_we         = 1'b0;
    push_valid     = 1'b0;
    push_job.bank  = bank_r;
    push_job.empty = (fill_r == '0);
    push_job.len   = LW'(fill_r);
    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end
    if (accept) begin
      if (esc_pend_r) begin
        esc_pend_nxt = 1'b0;
        if (fill_r == LAST) begin
          in_frame_nxt = 1'b0;
          fill_nxt     = '0;
        end else begin
          ram_we   = 1'b1;
          fill_nxt = AW'(fill_r + 1'b1);
        end
      end else if (b == start_r) begin
        in_frame_nxt = 1'b1;
        fill_nxt     = '0;
      end else if (!in_frame_r) begin
        // outside a frame: byte dropped
      end else if (b == esc_r) begin
        esc_pend_nxt = 1'b1;
      end else if (b == end_r) begin
        push_valid   = 1'b1;
        in_frame_nxt = 1'b0;
        fill_nxt     = '0;
        if (fill_r != '0) begin
          busy_nxt[bank_r] = 1'b1;
          bank_nxt         = ~bank_r;
        end
      end else if (fill_r < LIMIT) begin
        ram_we   = 1'b1;
        fill_nxt = AW'(fill_r + 1'b1);
      end else begin
        in_frame_nxt = 1'b0;
        fill_nxt     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      esc_pend_r <= 1'b0;
      fill_r     <= '0;
      bank_r     <= 1'b0;
      busy_r     <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      esc_pend_r <= esc_pend_nxt;
      fill_r     <= fill_nxt;
      bank_r     <= bank_nxt;
      busy_r     <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= efd_pkg::START_RST;
      end_r   <= efd_pkg::END_RST;
      esc_r   <= efd_pkg::ESC_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        efd_pkg::CFG_START: start_r <= cfg_wdata;
        efd_pkg::CFG_END:   end_r   <= cfg_wdata;
        efd_pkg::CFG_ESC:   esc_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

// ----- design/efd_job_fifo.sv -----
// Two-entry queue of release jobs between front and back end.
module efd_job_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  efd_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output efd_pkg::job_t pop_job,
  output logic          empty
);

  efd_pkg::job_t mem_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    count_r;
  logic          do_push, do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        mem_r[wr_ptr_r] <= push_job;
        wr_ptr_r        <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        count_r <= 2'(count_r + 2'd1);
      end else if (do_pop && !do_push) begin
        count_r <= 2'(count_r - 2'd1);
      end
    end
  end

endmodule

// ----- design/efd_back.sv -----
// Back end: drains a released frame from the payload RAM into the output register.
module efd_back #(
  parameter int MAX_BYTES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fifo_empty,
  input  efd_pkg::job_t                 pop_job,
  output logic                          pop,
  output efd_pkg::release_t             rel,
  output logic                          ram_re,
  output logic [$clog2(MAX_BYTES):0]    ram_raddr,
  input  logic [efd_pkg::BYTE_W-1:0]    ram_rdata,
  efd_out_if.source                     out_ch
);

  localparam int AW = $clog2(MAX_BYTES);
  localparam int LW = efd_pkg::MSG_LEN_W;

  logic          active_r, jbank_r, jempty_r;
  logic [LW-1:0] jlen_r;
  logic [AW-1:0] idx_r;
  logic          rd_valid_r, rd_last_r, rd_empty_r;
  logic [LW-1:0] rd_len_r;
  logic          out_valid_r, out_last_r, out_empty_r;
  logic [LW-1:0] out_len_r;
  logic [efd_pkg::BYTE_W-1:0] out_byte_r;
  logic          out_load, issue, issue_last;

  assign out_load   = rd_valid_r && (!out_valid_r || out_ch.ready);
  assign issue      = active_r && (!rd_valid_r || out_load);
  assign issue_last = jempty_r || (LW'(LW'(idx_r) + LW'(1)) == jlen_r);
  assign pop        = !active_r && !fifo_empty;
  // empty frames own no bank, so they never touch the RAM
  assign ram_re     = issue && !jempty_r;
  assign ram_raddr  = {jbank_r, idx_r};
  assign rel.valid  = issue && issue_last && !jempty_r;
  assign rel.bank   = jbank_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        active_r <= 1'b1;
        jbank_r  <= pop_job.bank;
        jempty_r <= pop_job.empty;
        jlen_r   <= pop_job.len;
        idx_r    <= '0;
      end else if (issue) begin
        if (issue_last) begin
          active_r <= 1'b0;
        end else begin
          idx_r <= AW'(idx_r + 1'b1);
        end
      end
      if (issue) begin
        rd_valid_r <= 1'b1;
        rd_last_r  <= issue_last;
        rd_empty_r <= jempty_r;
        rd_len_r   <= jlen_r;
      end else if (out_load) begin
        rd_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_byte_r  <= rd_empty_r ? '0 : ram_rdata;
        out_len_r   <= rd_len_r;
        out_last_r  <= rd_last_r;
        out_empty_r <= rd_empty_r;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.msg_byte    = out_byte_r;
  assign out_ch.msg_length  = out_len_r;
  assign out_ch.is_last     = out_last_r;
  assign out_ch.empty_frame = out_empty_r;

endmodule

// ----- design/escaped_frame_decoder_core.sv -----
// Byte-stuffing frame decoder top level: front end, job queue, two-bank RAM, back end.
//
// One received byte is taken per cycle while a frame is assembled. A closing byte
// queues the frame for release; after a frame with payload the front end moves on
// to the other bank of a two-bank payload RAM (2 x MAX_BYTES bytes), so the next
// frame is collected while the back end drains the previous one through a RAM read
// stage and an output register, at one result per cycle while the output is not
// stalled. The input stalls only while both banks hold frames waiting to drain or
// the two-entry job queue is full. An empty frame yields a single result. The RAM
// needs no clearing pass: only bytes written in a frame are read.
module escaped_frame_decoder_core #(
  parameter int MAX_BYTES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  efd_in_if.sink                        in_ch,
  efd_out_if.source                     out_ch,
  input  logic                          cfg_wr_en,
  input  logic [efd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [efd_pkg::BYTE_W-1:0]    cfg_wdata
);

  localparam int AW = $clog2(MAX_BYTES);

  logic                       push_valid, fifo_full, fifo_empty, pop;
  efd_pkg::job_t              push_job, pop_job;
  efd_pkg::release_t          rel;
  logic                       ram_we, ram_re;
  logic [AW:0]                ram_waddr, ram_raddr;
  logic [efd_pkg::BYTE_W-1:0] ram_wdata, ram_rdata;

  efd_front #(.MAX_BYTES(MAX_BYTES)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .push_valid (push_valid),
    .push_job   (push_job),
    .fifo_full  (fifo_full),
    .rel        (rel),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata)
  );

  efd_job_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push_valid),
    .push_job (push_job),
    .full     (fifo_full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (fifo_empty)
  );

  efd_ram #(.WIDTH(efd_pkg::BYTE_W), .DEPTH(2 ** (AW + 1))) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  efd_back #(.MAX_BYTES(MAX_BYTES)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_empty (fifo_empty),
    .pop_job    (pop_job),
    .pop        (pop),
    .rel        (rel),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .out_ch     (out_ch)
  );

`ifndef SYNTH
  a_no_bank_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr[AW] != ram_raddr[AW]))
    else $error("payload write hit the bank being drained");

  a_empty_frame_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.empty_frame) |->
      (out_ch.is_last && out_ch.msg_length == '0 && out_ch.msg_byte == '0))
    else $error("empty frame transfer malformed");

  a_payload_has_length: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.empty_frame) |-> (out_ch.msg_length != '0))
    else $error("payload transfer with zero length");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> !fifo_full)
    else $error("job issued into a full queue");
`endif

endmodule

// ----- dv/escaped_frame_decoder_core_tb.sv -----
// Testbench for escaped_frame_decoder_core: random framed byte streams vs. a behavioral decoder.
module escaped_frame_decoder_core_tb;

  localparam int BYTE_W       = efd_pkg::BYTE_W;
  localparam int MSG_LEN_W    = efd_pkg::MSG_LEN_W;
  localparam int CFG_IDX_W    = efd_pkg::CFG_IDX_W;
  localparam int GUARD_BYTES  = efd_pkg::GUARD_BYTES;
  localparam int MAX_BYTES    = 64;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES  = 400;
  localparam int LIMIT_CYCLES = 300000;

  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0]    msg_byte;
    logic [MSG_LEN_W-1:0] msg_length;
    logic                 is_last;
    logic                 empty_frame;
  } msg_result_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]    cfg_wdata;

  efd_in_if  rx_if ();
  efd_out_if msg_if ();

  escaped_frame_decoder_core #(
    .MAX_BYTES(MAX_BYTES)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (rx_if),
    .out_ch   (msg_if),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  logic [BYTE_W-1:0] rx_q[$];
  msg_result_t       msg_expect_q[$];
  int                rx_pushed;
  int                err_cnt;
  int                cycle_cnt;
  int                send_idle_pct;
  int                stall_pct;
  logic              rx_taken;
  logic              hold_go;
  logic              hold_done;
  int                hold_cnt;

  // decoder shadow state
  logic [BYTE_W-1:0] start_pat;
  logic [BYTE_W-1:0] end_pat;
  logic [BYTE_W-1:0] esc_pat;
  logic [BYTE_W-1:0] frame_buf[MAX_BYTES];
  int                frame_fill;
  logic              frame_open;
  logic              esc_armed;

  task automatic decode_rx_byte(input logic [BYTE_W-1:0] b);
    msg_result_t r;
    int n;
    if (esc_armed) begin
      esc_armed = 1'b0;
      if (frame_fill < MAX_BYTES) frame_buf[frame_fill] = b;
      frame_fill++;
      if (frame_fill >= MAX_BYTES) begin
        frame_open = 1'b0;
        frame_fill = 0;
      end
    end else if (b == start_pat) begin
      frame_open = 1'b1;
      frame_fill = 0;
    end else if (!frame_open) begin
      esc_armed = 1'b0;
    end else if (b == esc_pat) begin
      esc_armed = 1'b1;
    end else if (b == end_pat) begin
      n = frame_fill;
      frame_open = 1'b0;
      frame_fill = 0;
      if (n == 0) begin
        r = '{msg_byte: '0, msg_length: '0, is_last: 1'b1, empty_frame: 1'b1};
        msg_expect_q.push_back(r);
      end
      for (int k = 0; k < n; k++) begin
        r.msg_byte    = frame_buf[k];
        r.msg_length  = n[MSG_LEN_W-1:0];
        r.is_last     = (k == n - 1);
        r.empty_frame = 1'b0;
        msg_expect_q.push_back(r);
      end
    end else if (frame_fill < MAX_BYTES - GUARD_BYTES) begin
      frame_buf[frame_fill] = b;
      frame_fill++;
    end else begin
      frame_open = 1'b0;
      frame_fill = 0;
    end
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // transfer sampling and checking
  always @(posedge clk) begin
    msg_result_t exp_r;
    if (rst_n) begin
      rx_taken <= rx_if.valid && rx_if.ready;
      if (rx_if.valid && rx_if.ready) decode_rx_byte(rx_q.pop_front());
      if (msg_if.valid && msg_if.ready) begin
        if (msg_expect_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual byte %0d len %0d",
                   $time, msg_if.msg_byte, msg_if.msg_length);
          err_cnt++;
        end else begin
          exp_r = msg_expect_q.pop_front();
          if (!exp_r.empty_frame) check_field("msg_byte", exp_r.msg_byte, msg_if.msg_byte);
          check_field("msg_length", exp_r.msg_length, msg_if.msg_length);
          check_field("is_last", exp_r.is_last, msg_if.is_last);
          check_field("empty_frame", exp_r.empty_frame, msg_if.empty_frame);
        end
      end
    end
  end

  // input driver: holds an offered byte until its transfer
  always @(negedge clk) begin
    if (!rst_n) begin
      rx_if.valid   <= 1'b0;
      rx_if.rx_byte <= '0;
    end else if (!(rx_if.valid && !rx_taken)) begin
      if (rx_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= rx_q[0];
      end else begin
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= BYTE_W'($urandom_range(255));
      end
    end
  end

  // output ready, with a one-shot long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      msg_if.ready <= 1'b0;
    end else if (hold_go && !hold_done) begin
      msg_if.ready <= 1'b0;
      if (hold_cnt == HOLD_CYCLES - 1) hold_done <= 1'b1;
      hold_cnt <= hold_cnt + 1;
    end else begin
      msg_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("escaped_frame_decoder_core_tb NOT OK");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      efd_pkg::CFG_START: start_pat = v;
      efd_pkg::CFG_END:   end_pat   = v;
      efd_pkg::CFG_ESC:   esc_pat   = v;
      default:            ;
    endcase
  endtask

  task automatic set_patterns(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] e,
                              input logic [BYTE_W-1:0] c);
    write_reg(efd_pkg::CFG_START, s);
    write_reg(efd_pkg::CFG_END, e);
    write_reg(efd_pkg::CFG_ESC, c);
  endtask

  task automatic wait_idle();
    while (rx_q.size() != 0 || msg_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_rx(input logic [BYTE_W-1:0] b);
    rx_q.push_back(b);
    rx_pushed++;
  endtask

  task automatic push_payload(input int len, input int esc_pct);
    logic [BYTE_W-1:0] v;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(7))
        0:       v = start_pat;
        1:       v = end_pat;
        2:       v = esc_pat;
        default: v = BYTE_W'($urandom_range(255));
      endcase
      if (v == start_pat || v == end_pat || v == esc_pat || $urandom_range(99) < esc_pct)
        push_rx(esc_pat);
      push_rx(v);
    end
  endtask

  task automatic gen_traffic(input int n_items);
    int stop_at;
    int sel;
    stop_at = rx_pushed + n_items;
    while (rx_pushed < stop_at) begin
      sel = $urandom_range(99);
      if (sel < 70) begin
        push_rx(start_pat);
        push_payload($urandom_range(8), 15);
        push_rx(end_pat);
      end else if (sel < 80) begin
        push_rx(start_pat);
        push_payload($urandom_range(6), 15);
        if ($urandom_range(1)) push_rx(esc_pat);
      end else if (sel < 94) begin
        repeat ($urandom_range(1, 5)) push_rx(BYTE_W'($urandom_range(255)));
      end else begin
        push_rx(start_pat);
        case ($urandom_range(2))
          0:       push_payload($urandom_range(60, 66), 0);
          1:       push_payload($urandom_range(58, 64), 30);
          default: push_payload($urandom_range(60, 66), 100);
        endcase
        push_rx(end_pat);
      end
    end
  endtask

  initial begin
    logic [BYTE_W-1:0] s;
    logic [BYTE_W-1:0] e;
    logic [BYTE_W-1:0] c;
    logic [BYTE_W-1:0] dir_seq[] = '{
      8'h55, 8'h03,                             // ignored outside a frame
      8'h02, 8'h03,                             // empty frame
      8'h02, 8'h00, 8'hFF, 8'h03,               // extreme payload values
      8'h02, 8'h10, 8'h02, 8'h10, 8'h03,        // escaped start and end
      8'h10, 8'h10, 8'h03,                      // escaped escape
      8'h02, 8'hAA, 8'h02, 8'h11, 8'h03,        // restart mid-frame
      8'h02, 8'h80, 8'h10, 8'h03, 8'h03         // escape right before end
    };
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    msg_if.ready  = 1'b0;
    rx_taken      = 1'b0;
    hold_go       = 1'b0;
    hold_done     = 1'b0;
    hold_cnt      = 0;
    rx_pushed     = 0;
    err_cnt       = 0;
    cycle_cnt     = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    start_pat     = efd_pkg::START_RST;
    end_pat       = efd_pkg::END_RST;
    esc_pat       = efd_pkg::ESC_RST;
    frame_fill    = 0;
    frame_open    = 1'b0;
    esc_armed     = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_seq[i]) push_rx(dir_seq[i]);
    gen_traffic(20);
    wait_idle();

    set_patterns(8'h00, 8'hFF, 8'h80);
    write_reg(CFG_NONE, BYTE_W'($urandom_range(255)));
    gen_traffic(30);
    wait_idle();

    set_patterns(8'hFF, 8'h00, 8'h01);
    send_idle_pct = 77;
    gen_traffic(30);
    wait_idle();

    do begin
      s = BYTE_W'($urandom_range(255));
      e = BYTE_W'($urandom_range(255));
      c = BYTE_W'($urandom_range(255));
    end while (s == e || s == c || e == c);
    set_patterns(s, e, c);
    send_idle_pct = 0;
    stall_pct     = 77;
    gen_traffic(30);
    wait_idle();

    do begin
      s = BYTE_W'($urandom_range(255));
      e = BYTE_W'($urandom_range(255));
      c = BYTE_W'($urandom_range(255));
    end while (s == e || s == c || e == c);
    set_patterns(s, e, c);
    send_idle_pct = 28;
    stall_pct     = 28;
    gen_traffic(30);
    wait_idle();

    // start shares its value with escape: start takes precedence
    set_patterns(8'h07, 8'h08, 8'h07);
    gen_traffic(10);
    wait_idle();

    // end shares its value with escape: escape takes precedence
    set_patterns(8'h05, 8'h09, 8'h09);
    gen_traffic(10);
    wait_idle();

    // fill the block while the output is held off
    set_patterns(efd_pkg::START_RST, efd_pkg::END_RST, efd_pkg::ESC_RST);
    send_idle_pct = 0;
    stall_pct     = 0;
    gen_traffic(60);
    hold_go = 1'b1;
    while (!hold_done) @(posedge clk);
    hold_go = 1'b0;
    while (rx_q.size() != 0 || msg_expect_q.size() != 0) @(posedge clk);

    send_idle_pct = 28;
    stall_pct     = 28;
    gen_traffic(15);
    wait_idle();

    if (err_cnt == 0) begin
      $display("escaped_frame_decoder_core_tb OK");
    end else begin
      $display("escaped_frame_decoder_core_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- escaped_frame_decoder_core.f -----
design/efd_pkg.sv
design/efd_in_if.sv
design/efd_out_if.sv
design/efd_ram.sv
design/efd_front.sv
design/efd_job_fifo.sv
design/efd_back.sv
design/escaped_frame_decoder_core.sv
dv/escaped_frame_decoder_core_tb.sv
